FILE: sv/spg_pkg.sv
// spg_pkg: shared types and constants for the softened pair gravity block
// no dependencies; imported by every spg module and the top level

package spg_pkg;

  // widths of the raw fields
  localparam int FieldW = 32;
  localparam int MassW  = 31;

  // input queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // classified item: magnitudes, signs and clamped mass
  typedef struct packed {
    logic [FieldW-1:0] mx;
    logic [FieldW-1:0] my;
    logic              sx;
    logic              sy;
    logic [MassW-1:0]  mass;
  } spg_item_t;

endpackage

FILE: sv/softened_pair_gravity.sv
// softened_pair_gravity: Plummer-softened pair acceleration, top level
// depends on spg_pkg, spg_front, spg_queue, spg_back
//
//   channel   | group               | payload
//   ----------+---------------------+--------------------------------------
//   input     | s_tvalid / s_tready | dx, dy, source_mass in s_tdata
//   result    | m_tvalid / m_tready | accel_x, accel_y in m_tdata, status in m_tuser
//   config    | psel / penable      | gravity_constant @0, softening_length @4
//
// one transaction per cycle sustained while results are taken; the back
// pipeline holds the 33-stage square root and the two 33-stage dividers
// rst is synchronous and empties the front register, queue and pipeline
// a stalled result stops the back pipeline; the front and a 4-deep queue
// keep taking input until the queue fills

module softened_pair_gravity import spg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // dx [31:0], dy [63:32], source_mass [95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // accel_x [31:0], accel_y [63:32]
  output logic [1:0]  m_tuser,   // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] gravity_constant, softening_length;
  logic        front_valid, q_ready, q_valid, back_ready;
  spg_item_t   front_item, q_item;
  logic [31:0] accel_x, accel_y;
  logic [1:0]  status;

  // configuration registers
  assign pready = 1'b1;
  assign prdata = paddr[2] ? softening_length : gravity_constant;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_constant <= 32'd65536;
      softening_length <= 32'd0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) softening_length <= pwdata;
      else gravity_constant <= pwdata;
    end
  end

  // front: take and classify
  spg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .out_valid (front_valid),
    .out_ready (q_ready),
    .out_item  (front_item)
  );

  // queue between front and back
  spg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (q_ready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_ready (back_ready),
    .out_item  (q_item)
  );

  // back: arithmetic pipeline
  spg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (q_valid),
    .in_ready         (back_ready),
    .in_item          (q_item),
    .gravity_constant (gravity_constant),
    .softening_length (softening_length),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .accel_x          (accel_x),
    .accel_y          (accel_y),
    .status           (status)
  );

  assign m_tdata = {accel_y, accel_x};
  assign m_tuser = status;

  // status codes stay in range
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_SAT || m_tuser == ST_ZERO))
    else $error("bad status code");

  // zero denominator gives zero acceleration
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ZERO |-> m_tdata == 64'd0)
    else $error("zero status with nonzero data");

  // saturation leaves a component at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_SAT |->
      (accel_x == 32'h7FFF_FFFF || accel_x == 32'h8000_0000 ||
       accel_y == 32'h7FFF_FFFF || accel_y == 32'h8000_0000))
    else $error("saturated status without a limit value");

  // front holds an item whenever input is refused
  a_front_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> front_valid && !q_ready)
    else $error("input refused with room");

endmodule

FILE: sv/spg_front.sv
// spg_front: input register that takes a transaction and classifies it
// depends on spg_pkg

module spg_front import spg_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [95:0]     s_tdata,   // dx [31:0], dy [63:32], source_mass [95:64]
  output logic            out_valid,
  input  logic            out_ready,
  output spg_item_t       out_item
);

  logic [FieldW-1:0] dx, dy, mass;
  logic              fv;
  spg_item_t         item;

  assign dx   = s_tdata[31:0];
  assign dy   = s_tdata[63:32];
  assign mass = s_tdata[95:64];

  assign s_tready  = !fv || out_ready;
  assign out_valid = fv;
  assign out_item  = item;

  // magnitude and sign per component, negative mass clamps to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      item.sx   <= dx[FieldW-1];
      item.sy   <= dy[FieldW-1];
      item.mx   <= dx[FieldW-1] ? (FieldW'(0) - dx) : dx;
      item.my   <= dy[FieldW-1] ? (FieldW'(0) - dy) : dy;
      item.mass <= mass[FieldW-1] ? '0 : mass[MassW-1:0];
    end
  end

endmodule

FILE: sv/spg_queue.sv
// spg_queue: short queue of classified items between front and back
// depends on spg_pkg

module spg_queue import spg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  spg_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output spg_item_t out_item
);

  spg_item_t        entries [QDepth];
  logic [QAw-1:0]   wr_ptr, rd_ptr;
  logic [QAw:0]     count;
  logic             push, pop;

  assign in_ready  = (count != QAw'(0) + (QAw+1)'(QDepth));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_item;
  end

endmodule

FILE: sv/spg_back.sv
// spg_back: arithmetic pipeline: squares, integer square root, cube of
// radius, and two 32-step restoring dividers; depends on spg_pkg

module spg_back import spg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spg_item_t         in_item,
  input  logic [31:0]       gravity_constant,
  input  logic [31:0]       softening_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       accel_x,
  output logic [31:0]       accel_y,
  output logic [1:0]        status
);

  localparam int RW    = 2 * FieldW + 2;          // radius squared
  localparam int RTW   = RW + 2;                  // root remainder work width
  localparam int SW    = FieldW + 1;              // root
  localparam int GW    = FieldW + MassW;          // G times mass
  localparam int NW    = GW + FieldW + FRAC_BITS; // numerator
  localparam int HW    = RW / 2;                  // half the radius-squared width
  localparam int DNW   = RW + SW;                 // denominator
  localparam int QB    = FieldW;                  // quotient bits
  localparam int DW    = DNW + QB;                // divider work width

  typedef struct packed {
    logic [RW-1:0] r2;
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic          sx;
    logic          sy;
  } sq_pay_t;

  typedef struct packed {
    logic [DNW-1:0] d;
    logic           sx;
    logic           sy;
    logic           zero;
    logic           bx;
    logic           by;
  } dv_pay_t;

  logic adv;
  logic ov;

  assign adv       = !ov || out_ready;
  assign in_ready  = adv;
  assign out_valid = ov;

  // stage 0: squares and G times mass
  logic                v0;
  logic [2*FieldW-1:0] px, py, pe;
  logic [GW-1:0]       gm;
  logic [FieldW-1:0]   mx0, my0;
  logic                sx0, sy0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_valid;
    if (adv) begin
      px  <= in_item.mx * in_item.mx;
      py  <= in_item.my * in_item.my;
      pe  <= softening_length * softening_length;
      gm  <= GW'(gravity_constant) * GW'(in_item.mass);
      mx0 <= in_item.mx;
      my0 <= in_item.my;
      sx0 <= in_item.sx;
      sy0 <= in_item.sy;
    end
  end

  // stage 1: radius squared and numerator partial products
  logic                 v1;
  logic [RW-1:0]        r2_1;
  logic [2*FieldW-1:0]  nxl, nyl;
  logic [GW-1:0]        nxh, nyh;
  logic                 sx1, sy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= v0;
    if (adv) begin
      r2_1 <= RW'(px) + RW'(py) + RW'(pe);
      nxl  <= gm[FieldW-1:0] * mx0;
      nyl  <= gm[FieldW-1:0] * my0;
      nxh  <= GW'(gm[GW-1:FieldW]) * GW'(mx0);
      nyh  <= GW'(gm[GW-1:FieldW]) * GW'(my0);
      sx1  <= sx0;
      sy1  <= sy0;
    end
  end

  // stage 2: numerators scaled by the fraction
  logic    v2;
  sq_pay_t p2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      p2.r2 <= r2_1;
      p2.nx <= (NW'(nxl) + (NW'(nxh) << FieldW)) << FRAC_BITS;
      p2.ny <= (NW'(nyl) + (NW'(nyh) << FieldW)) << FRAC_BITS;
      p2.sx <= sx1;
      p2.sy <= sy1;
    end
  end

  // square root, one result bit per stage from the top
  logic          sq_v    [SW];
  logic [RTW-1:0] sq_rem [SW];
  logic [SW-1:0] sq_root [SW];
  sq_pay_t       sq_pay  [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam int B = SW - 1 - k;
    logic           v_in;
    logic [RTW-1:0] rem_in, trial;
    logic [SW-1:0]  root_in;
    sq_pay_t        pay_in;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in    = v2;
      assign rem_in  = RTW'(p2.r2);
      assign root_in = '0;
      assign pay_in  = p2;
    end else begin : g_next
      assign v_in    = sq_v[k-1];
      assign rem_in  = sq_rem[k-1];
      assign root_in = sq_root[k-1];
      assign pay_in  = sq_pay[k-1];
    end

    assign trial = (RTW'(root_in) << (B + 1)) + (RTW'(1) << (2 * B));
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) sq_v[k] <= 1'b0;
      else if (adv) sq_v[k] <= v_in;
      if (adv) begin
        sq_rem[k]  <= ge ? rem_in - trial : rem_in;
        sq_root[k] <= ge ? (root_in | (SW'(1) << B)) : root_in;
        sq_pay[k]  <= pay_in;
      end
    end
  end

  // denominator partial products
  logic          vm1;
  logic [2*HW-1:0] dhi, dlo;
  logic [NW-1:0] nx_m1, ny_m1;
  logic          sx_m1, sy_m1, zero_m1;

  always_ff @(posedge clk) begin
    if (rst) vm1 <= 1'b0;
    else if (adv) vm1 <= sq_v[SW-1];
    if (adv) begin
      dhi     <= sq_pay[SW-1].r2[RW-1:HW] * sq_root[SW-1];
      dlo     <= sq_pay[SW-1].r2[HW-1:0] * sq_root[SW-1];
      nx_m1   <= sq_pay[SW-1].nx;
      ny_m1   <= sq_pay[SW-1].ny;
      sx_m1   <= sq_pay[SW-1].sx;
      sy_m1   <= sq_pay[SW-1].sy;
      zero_m1 <= (sq_pay[SW-1].r2 == '0);
    end
  end

  // denominator sum
  logic           vm2;
  logic [DNW-1:0] dm2;
  logic [NW-1:0]  nx_m2, ny_m2;
  logic           sx_m2, sy_m2, zero_m2;

  always_ff @(posedge clk) begin
    if (rst) vm2 <= 1'b0;
    else if (adv) vm2 <= vm1;
    if (adv) begin
      dm2     <= (DNW'(dhi) << HW) + DNW'(dlo);
      nx_m2   <= nx_m1;
      ny_m2   <= ny_m1;
      sx_m2   <= sx_m1;
      sy_m2   <= sy_m1;
      zero_m2 <= zero_m1;
    end
  end

  // divider: entry stage flags quotients too large for 32 bits
  logic          dv_v   [QB+1];
  dv_pay_t       dv_pay [QB+1];
  logic [DW-1:0] rx [QB+1];
  logic [DW-1:0] ry [QB+1];
  logic [QB-1:0] qx [QB+1];
  logic [QB-1:0] qy [QB+1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= vm2;
    if (adv) begin
      dv_pay[0].d    <= dm2;
      dv_pay[0].sx   <= sx_m2;
      dv_pay[0].sy   <= sy_m2;
      dv_pay[0].zero <= zero_m2;
      dv_pay[0].bx   <= DW'(nx_m2) >= (DW'(dm2) << QB);
      dv_pay[0].by   <= DW'(ny_m2) >= (DW'(dm2) << QB);
      rx[0]          <= DW'(nx_m2);
      ry[0]          <= DW'(ny_m2);
      qx[0]          <= '0;
      qy[0]          <= '0;
    end
  end

  // one quotient bit per stage for each component
  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int B = QB - j;
    logic [DW-1:0] dsh;
    logic          gex, gey;

    assign dsh = DW'(dv_pay[j-1].d) << B;
    assign gex = (rx[j-1] >= dsh);
    assign gey = (ry[j-1] >= dsh);

    always_ff @(posedge clk) begin
      if (rst) dv_v[j] <= 1'b0;
      else if (adv) dv_v[j] <= dv_v[j-1];
      if (adv) begin
        dv_pay[j] <= dv_pay[j-1];
        rx[j]     <= gex ? rx[j-1] - dsh : rx[j-1];
        ry[j]     <= gey ? ry[j-1] - dsh : ry[j-1];
        qx[j]     <= qx[j-1] | (gex ? (QB'(1) << B) : '0);
        qy[j]     <= qy[j-1] | (gey ? (QB'(1) << B) : '0);
      end
    end
  end

  // saturation, sign and status
  logic [QB-1:0] lim_x, lim_y, mag_x, mag_y;
  logic          sat_x, sat_y;
  dv_pay_t       pf;

  assign pf    = dv_pay[QB];
  assign lim_x = pf.sx ? {1'b1, (QB-1)'(0)} : {1'b0, {(QB-1){1'b1}}};
  assign lim_y = pf.sy ? {1'b1, (QB-1)'(0)} : {1'b0, {(QB-1){1'b1}}};
  assign sat_x = pf.bx || (qx[QB] > lim_x);
  assign sat_y = pf.by || (qy[QB] > lim_y);
  assign mag_x = sat_x ? lim_x : qx[QB];
  assign mag_y = sat_y ? lim_y : qy[QB];

  // output register
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= dv_v[QB];
    if (adv) begin
      priority if (pf.zero) begin
        accel_x <= '0;
        accel_y <= '0;
        status  <= ST_ZERO;
      end else begin
        accel_x <= pf.sx ? QB'(0) - mag_x : mag_x;
        accel_y <= pf.sy ? QB'(0) - mag_y : mag_y;
        status  <= (sat_x || sat_y) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

FILE: verif/tb_softened_pair_gravity.sv
// tb_softened_pair_gravity: randomized stream test of the softened pair gravity block
// depends on spg_pkg and softened_pair_gravity; predicts each result with wide integer math
`timescale 1ns / 100ps

module tb_softened_pair_gravity;
  import spg_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam logic [2:0] ADDR_GRAV = 3'd0;
  localparam logic [2:0] ADDR_SOFT = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // idle percentages per side, and long receiver hold-off
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;

  softened_pair_gravity #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // expected pair accelerations, computed at input acceptance
  class accel_board;
    logic [31:0] grav = 32'd65536;
    logic [31:0] soft_len = 32'd0;
    logic [65:0] pending[$];
    int errors = 0;

    function logic [31:0] axis_accel(logic [63:0] gm, logic [31:0] d, logic [127:0] den,
                                     ref bit sat);
      logic neg;
      logic [31:0] mag;
      logic [127:0] num, q;
      logic [31:0] lim;
      neg = d[31];
      mag = neg ? -d : d;
      num = (128'(gm) * 128'(mag)) << FRAC_BITS;
      q = num / den;
      lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      if (q > 128'(lim)) begin
        sat = 1'b1;
        q = 128'(lim);
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_input(logic [31:0] dx, logic [31:0] dy, logic [31:0] m);
      logic [31:0] ax, ay, mx, my, mpos;
      logic [127:0] r2, den;
      logic [63:0] s, cand, gm;
      bit sat;
      sat = 1'b0;
      mx = dx[31] ? -dx : dx;
      my = dy[31] ? -dy : dy;
      mpos = m[31] ? 32'd0 : m;
      r2 = 128'(mx) * mx + 128'(my) * my + 128'(soft_len) * soft_len;
      if (r2 == 0) begin
        pending.push_back({ST_ZERO, 64'd0});
        return;
      end
      s = 0;
      for (int b = 40; b >= 0; b--) begin
        cand = s | (64'd1 << b);
        if (128'(cand) * cand <= r2) s = cand;
      end
      den = r2 * s;
      gm = 64'(grav) * mpos;
      ax = axis_accel(gm, dx, den, sat);
      ay = axis_accel(gm, dy, den, sat);
      pending.push_back({sat ? ST_SAT : ST_OK, ay, ax});
    endfunction

    function void check_result(logic [63:0] data, logic [1:0] st);
      logic [65:0] e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result accel %h status %0d", $time, data, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[31:0] !== e[31:0]) begin
        $display("%0t: accel_x expected %h actual %h", $time, e[31:0], data[31:0]);
        errors++;
      end
      if (data[63:32] !== e[63:32]) begin
        $display("%0t: accel_y expected %h actual %h", $time, e[63:32], data[63:32]);
        errors++;
      end
      if (st !== e[65:64]) begin
        $display("%0t: status expected %0d actual %0d", $time, e[65:64], st);
        errors++;
      end
    endfunction
  endclass

  accel_board board = new();

  // result side: random stalls and the long hold-off
  always @(posedge clk) begin
    if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_GRAV) board.grav = value;
    else board.soft_len = value;
  endtask

  // offer one transaction, with random idle cycles ahead of it
  task automatic send_pair(input logic [31:0] dx, input logic [31:0] dy,
                           input logic [31:0] m);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {m, dy, dx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(dx, dy, m);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(65536 * 8) - 65536 * 4;
      2: return 32'h8000_0000 + $urandom_range(3);
      3: return 32'h7fff_ffff - $urandom_range(3);
      4: return $urandom_range(255) - 128;
      default: return $urandom_range(65536 * 256) - 65536 * 128;
    endcase
  endfunction

  function automatic logic [31:0] rand_cfg();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(65536 * 4);
      2: return $urandom_range(255);
      default: return $urandom_range(65536 * 64);
    endcase
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && hold_cycles == 0 && recv_idle == 0) hold_cycles = 200;
      send_pair(rand_field(), rand_field(), rand_field());
    end
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero denominator, extremes, negative mass, saturation
    send_pair(32'd0, 32'd0, 32'd65536);
    send_pair(32'd0, 32'd0, 32'h8000_0000);
    send_pair(32'd65536, 32'd0, 32'd65536);
    send_pair(32'd0, -32'sd65536, 32'd65536);
    send_pair(32'd65536, 32'd65536, 32'hffff_ffff);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_pair(32'd1, 32'd0, 32'h7fff_ffff);
    send_pair(-32'sd1, -32'sd1, 32'h7fff_ffff);
    send_pair(32'hffff_ffff, 32'h0000_0001, 32'd1);
    send_pair(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_pair(32'haaaa_aaaa, 32'h5555_5555, 32'h2aaa_aaaa);
    drain();
    reg_write(ADDR_GRAV, 32'hffff_ffff);
    reg_write(ADDR_SOFT, 32'd65536);
    send_pair(32'd0, 32'd0, 32'd65536);
    send_pair(32'd1, 32'd1, 32'h7fff_ffff);
    send_pair(32'h8000_0000, 32'd0, 32'h7fff_ffff);
    drain();
    reg_write(ADDR_GRAV, 32'd0);
    reg_write(ADDR_SOFT, 32'hffff_ffff);
    send_pair(32'd0, 32'd0, 32'h7fff_ffff);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    drain();

    // random phases with different settings and idle mixes
    for (int p = 0; p < 6; p++) begin
      reg_write(ADDR_GRAV, rand_cfg());
      reg_write(ADDR_SOFT, (p % 3 == 0) ? 32'd0 : rand_cfg());
      send_idle = (p < 2) ? 22 : (p < 4) ? 47 : 0;
      recv_idle = (p < 2) ? 47 : (p < 4) ? 22 : 0;
      random_phase(105);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: softened_pair_gravity.f
sv/spg_pkg.sv
sv/spg_front.sv
sv/spg_queue.sv
sv/spg_back.sv
sv/softened_pair_gravity.sv
verif/tb_softened_pair_gravity.sv
